FILE: hdl/ptm_pkg.sv
// Shared types and constants for the four-level page table mapper.
// Holds the microcode word layout, step addresses, status codes and entry constants.
// Used by ptm_sequencer, ptm_datapath and four_level_page_table_mapper; no dependencies.
package ptm_pkg;

  // Pool size default and table geometry
  localparam int unsigned POOL_TABLES_DEF = 16;
  localparam int unsigned ENTRIES         = 512;
  localparam int unsigned IDX_W           = 9;
  localparam int unsigned PFN_W           = 20;
  localparam logic [31:0] POOL_BASE_RST   = 32'h0030_0000;

  // Present and write bits of a table entry
  localparam logic [11:0] PTE_PW = 12'h003;

  // Result status codes
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_MIS_VA = 3'd1;
  localparam logic [2:0] ST_MIS_PA = 3'd2;
  localparam logic [2:0] ST_MAPPED = 3'd3;
  localparam logic [2:0] ST_FULL   = 3'd4;

  // Microprogram step addresses
  localparam int unsigned STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_IDLE  = 3'd0;
  localparam logic [STEP_W-1:0] STEP_CHECK = 3'd1;
  localparam logic [STEP_W-1:0] STEP_READ  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_EVAL  = 3'd3;
  localparam logic [STEP_W-1:0] STEP_EMIT  = 3'd4;

  // Datapath action of one step
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_CHECK,
    ACT_READ,
    ACT_EVAL,
    ACT_EMIT
  } act_e;

  // Jump condition of one step
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_GO,
    COND_MIS,
    COND_CONT
  } cond_e;

  // One control word: action, jump condition, jump target
  typedef struct packed {
    act_e              act;
    cond_e             cond;
    logic [STEP_W-1:0] target;
  } ctl_t;

  // Datapath flags seen by the sequencer and the top level
  typedef struct packed {
    logic go;
    logic mis;
    logic cont;
    logic clearing;
  } flags_t;

endpackage

FILE: hdl/ptm_sequencer.sv
// Microcode sequencer: step counter plus a read-only control program.
// Each step issues one control word and may branch on a datapath flag.
// Depends on ptm_pkg.
module ptm_sequencer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ptm_pkg::flags_t flags_i,
  output ptm_pkg::ctl_t   ctl_o
);

  logic [ptm_pkg::STEP_W-1:0] step_q, step_d;
  logic                       taken;

  // Control program, indexed by step
  function automatic ptm_pkg::ctl_t ucode(input logic [ptm_pkg::STEP_W-1:0] step);
    ptm_pkg::ctl_t w;
    w.act    = ptm_pkg::ACT_NONE;
    w.cond   = ptm_pkg::COND_ALWAYS;
    w.target = ptm_pkg::STEP_IDLE;
    unique case (step)
      ptm_pkg::STEP_IDLE: begin
        w.act    = ptm_pkg::ACT_LOAD;
        w.cond   = ptm_pkg::COND_NO_GO;
        w.target = ptm_pkg::STEP_IDLE;
      end
      ptm_pkg::STEP_CHECK: begin
        w.act    = ptm_pkg::ACT_CHECK;
        w.cond   = ptm_pkg::COND_MIS;
        w.target = ptm_pkg::STEP_EMIT;
      end
      ptm_pkg::STEP_READ: begin
        w.act    = ptm_pkg::ACT_READ;
        w.cond   = ptm_pkg::COND_NEVER;
        w.target = ptm_pkg::STEP_IDLE;
      end
      ptm_pkg::STEP_EVAL: begin
        w.act    = ptm_pkg::ACT_EVAL;
        w.cond   = ptm_pkg::COND_CONT;
        w.target = ptm_pkg::STEP_READ;
      end
      ptm_pkg::STEP_EMIT: begin
        w.act    = ptm_pkg::ACT_EMIT;
        w.cond   = ptm_pkg::COND_ALWAYS;
        w.target = ptm_pkg::STEP_IDLE;
      end
      default: begin
        w.act    = ptm_pkg::ACT_NONE;
        w.cond   = ptm_pkg::COND_ALWAYS;
        w.target = ptm_pkg::STEP_IDLE;
      end
    endcase
    return w;
  endfunction

  assign ctl_o = ucode(step_q);

  // Evaluate the branch condition
  always_comb begin
    unique case (ctl_o.cond)
      ptm_pkg::COND_NEVER:  taken = 1'b0;
      ptm_pkg::COND_ALWAYS: taken = 1'b1;
      ptm_pkg::COND_NO_GO:  taken = !flags_i.go;
      ptm_pkg::COND_MIS:    taken = flags_i.mis;
      ptm_pkg::COND_CONT:   taken = flags_i.cont;
      default:              taken = 1'b1;
    endcase
    step_d = taken ? ctl_o.target : step_q + ptm_pkg::STEP_W'(1);
  end

  // Advance the step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ptm_pkg::STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

FILE: hdl/ptm_datapath.sv
// Walk datapath: request registers, table memory with clearing pass, pool counter.
// Executes the action named by the current control word and reports branch flags.
// Depends on ptm_pkg.
module ptm_datapath #(
  parameter int unsigned POOL_TABLES = ptm_pkg::POOL_TABLES_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ptm_pkg::ctl_t   ctl_i,
  input  logic            start_i,
  input  logic [31:0]     pool_base_i,
  input  logic [63:0]     virtual_address_i,
  input  logic [63:0]     physical_address_i,
  output ptm_pkg::flags_t flags_o,
  output logic [2:0]      status_o,
  output logic [31:0]     leaf_table_address_o,
  output logic [4:0]      tables_in_use_o
);

  localparam int unsigned TBL_W = $clog2(POOL_TABLES);
  localparam int unsigned CNT_W = $clog2(POOL_TABLES + 1);
  localparam int unsigned AW    = TBL_W + ptm_pkg::IDX_W;
  localparam int unsigned DEPTH = POOL_TABLES * ptm_pkg::ENTRIES;
  localparam int unsigned VI_W  = 4 * ptm_pkg::IDX_W;
  localparam logic [1:0]  LVL_TOP  = 2'd3;
  localparam logic [1:0]  LVL_LEAF = 2'd0;

  // Table store and its read register; bit 64 marks an entry written while
  // its table was already taken from the pool. Entries written to a table
  // before it is taken read as empty once it is taken.
  logic [64:0] mem [DEPTH];
  logic [64:0] rd_q;

  logic          clr_q;
  logic [AW-1:0] clr_addr_q;

  logic [VI_W-1:0]  va_idx_q;
  logic [51:0]      pa_q;
  logic             mis_va_q, mis_pa_q;
  logic [TBL_W-1:0] cur_q;
  logic [1:0]       level_q;
  logic [CNT_W-1:0] used_q;
  logic [2:0]       status_q;
  logic [31:0]      leaf_q;

  logic [ptm_pkg::IDX_W-1:0] slot;
  logic [AW-1:0]             rd_addr;
  logic [ptm_pkg::PFN_W-1:0] base_pfn, off_pfn, cur_pfn, new_pfn;
  logic                      present, off_ok, full, is_leaf, go;
  logic                      cur_alloc, link_alloc;
  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  logic [64:0]               wr_data;

  // Pick the index for the current level
  always_comb begin
    unique case (level_q)
      2'd3:    slot = va_idx_q[4*ptm_pkg::IDX_W-1:3*ptm_pkg::IDX_W];
      2'd2:    slot = va_idx_q[3*ptm_pkg::IDX_W-1:2*ptm_pkg::IDX_W];
      2'd1:    slot = va_idx_q[2*ptm_pkg::IDX_W-1:ptm_pkg::IDX_W];
      default: slot = va_idx_q[ptm_pkg::IDX_W-1:0];
    endcase
  end

  assign rd_addr  = {cur_q, slot};
  assign base_pfn = pool_base_i[31:12];
  assign off_pfn  = rd_q[31:12] - base_pfn;
  assign off_ok   = off_pfn < ptm_pkg::PFN_W'(POOL_TABLES);
  assign cur_pfn  = base_pfn + ptm_pkg::PFN_W'(cur_q);
  assign new_pfn  = base_pfn + ptm_pkg::PFN_W'(used_q);
  // Current table taken now, and taken once this step links a new table
  assign cur_alloc  = CNT_W'(cur_q) < used_q;
  assign link_alloc = CNT_W'(cur_q) <= used_q;
  assign present  = rd_q[0] && (rd_q[64] || !cur_alloc);
  assign full     = used_q >= CNT_W'(POOL_TABLES);
  assign is_leaf  = level_q == LVL_LEAF;
  assign go       = start_i && !clr_q;

  // Flags for the sequencer
  assign flags_o.go       = go;
  assign flags_o.mis      = mis_va_q || mis_pa_q;
  assign flags_o.cont     = !is_leaf && (present ? off_ok : !full);
  assign flags_o.clearing = clr_q;

  // Select the memory write: clearing pass, new table link or leaf entry
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_addr;
    wr_data = '0;
    if (clr_q) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_q;
    end else if (ctl_i.act == ptm_pkg::ACT_EVAL && !present && (is_leaf || !full)) begin
      wr_en   = 1'b1;
      wr_data = is_leaf ? {cur_alloc, pa_q, ptm_pkg::PTE_PW}
                        : {link_alloc, 32'h0, new_pfn, ptm_pkg::PTE_PW};
    end
  end

  // Memory write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl_i.act == ptm_pkg::ACT_READ) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Walk registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
      va_idx_q   <= '0;
      pa_q       <= '0;
      mis_va_q   <= 1'b0;
      mis_pa_q   <= 1'b0;
      cur_q      <= '0;
      level_q    <= LVL_TOP;
      used_q     <= CNT_W'(1);
      status_q   <= ptm_pkg::ST_OK;
      leaf_q     <= '0;
    end else begin
      // Sweep the store once after reset
      if (clr_q) begin
        clr_addr_q <= clr_addr_q + AW'(1);
        if (clr_addr_q == AW'(DEPTH - 1)) begin
          clr_q <= 1'b0;
        end
      end
      unique case (ctl_i.act)
        ptm_pkg::ACT_LOAD: begin
          if (go) begin
            va_idx_q <= virtual_address_i[47:12];
            pa_q     <= physical_address_i[63:12];
            mis_va_q <= |virtual_address_i[11:0];
            mis_pa_q <= |physical_address_i[11:0];
            cur_q    <= '0;
            level_q  <= LVL_TOP;
          end
        end
        ptm_pkg::ACT_CHECK: begin
          leaf_q <= '0;
          if (mis_va_q) begin
            status_q <= ptm_pkg::ST_MIS_VA;
          end else begin
            status_q <= ptm_pkg::ST_MIS_PA;
          end
        end
        ptm_pkg::ACT_EVAL: begin
          if (is_leaf) begin
            leaf_q   <= {cur_pfn, 12'h000};
            status_q <= present ? ptm_pkg::ST_MAPPED : ptm_pkg::ST_OK;
          end else if (present) begin
            if (off_ok) begin
              cur_q   <= TBL_W'(off_pfn);
              level_q <= level_q - 2'd1;
            end else begin
              leaf_q   <= {cur_pfn, 12'h000};
              status_q <= ptm_pkg::ST_FULL;
            end
          end else if (full) begin
            leaf_q   <= {cur_pfn, 12'h000};
            status_q <= ptm_pkg::ST_FULL;
          end else begin
            cur_q   <= TBL_W'(used_q);
            used_q  <= used_q + CNT_W'(1);
            level_q <= level_q - 2'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign status_o             = status_q;
  assign leaf_table_address_o = leaf_q;
  assign tables_in_use_o      = 5'(used_q);

endmodule

FILE: hdl/four_level_page_table_mapper.sv
// Top level of the four-level page table mapper.
// Holds the pool base register and joins ptm_sequencer and ptm_datapath.
// Depends on ptm_pkg, ptm_sequencer and ptm_datapath.
//
// Usage: drive virtual_address_i and physical_address_i with start high; the
// request word is taken at a clock edge where start is high and busy is low.
// One result word follows per request: done_o is high for exactly one cycle
// with status_o, leaf_table_address_o and tables_in_use_o valid. The receiver
// cannot stall; done_o marks the result only in that cycle.
// Sequence: after the accepting edge a full walk runs CHECK, then READ and
// EVAL for each of four dependent levels, then EMIT, which raises done_o;
// a new request is taken only back in IDLE, after EMIT. A misaligned address
// goes from CHECK straight to EMIT; an exhausted pool at an upper level
// reports earlier than a full walk.
// pool_base_we_i writes pool_base_i at any edge; change it only while idle.
// Reset: the pool holds only the root table and a clearing pass zeroes the
// whole table memory, during which busy stays high.
module four_level_page_table_mapper #(
  parameter int unsigned POOL_TABLES = ptm_pkg::POOL_TABLES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] virtual_address_i,
  input  logic [63:0] physical_address_i,
  input  logic        pool_base_we_i,
  input  logic [31:0] pool_base_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [31:0] leaf_table_address_o,
  output logic [4:0]  tables_in_use_o
);

  ptm_pkg::ctl_t   ctl;
  ptm_pkg::flags_t flags;
  logic [31:0]     pool_base_q;

  // Pool base configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q <= ptm_pkg::POOL_BASE_RST;
    end else if (pool_base_we_i) begin
      pool_base_q <= pool_base_i;
    end
  end

  ptm_sequencer u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctl_o   (ctl)
  );

  ptm_datapath #(
    .POOL_TABLES (POOL_TABLES)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .ctl_i                (ctl),
    .start_i              (start),
    .pool_base_i          (pool_base_q),
    .virtual_address_i    (virtual_address_i),
    .physical_address_i   (physical_address_i),
    .flags_o              (flags),
    .status_o             (status_o),
    .leaf_table_address_o (leaf_table_address_o),
    .tables_in_use_o      (tables_in_use_o)
  );

  // Busy outside the idle step and during the clearing pass
  assign busy   = flags.clearing || (ctl.act != ptm_pkg::ACT_LOAD);
  assign done_o = ctl.act == ptm_pkg::ACT_EMIT;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_done_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy)
    else $error("sequencer did not return to idle after a result");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o <= ptm_pkg::ST_FULL))
    else $error("result carries an undefined status");

  a_misaligned_leaf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ptm_pkg::ST_MIS_VA || status_o == ptm_pkg::ST_MIS_PA))
      |-> (leaf_table_address_o == 32'h0))
    else $error("misaligned request reported a table address");

endmodule
